// File: hw/rtl/tkdt_pkg.sv
// shared types and constants for the tick key debounce timer
package tkdt_pkg;

   localparam int unsigned REQ_TYPE_W   = 2;
   localparam int unsigned DELAY_W      = 16;
   localparam int unsigned PERIOD_W     = 10;
   localparam int unsigned WINDOW_W     = 8;
   localparam int unsigned INTEG_W      = 7;
   localparam int unsigned CSR_INDEX_W  = 1;
   localparam int unsigned CSR_DATA_W   = 10;

   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PACKET_PERIOD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS  = 1'd1;

   localparam logic [6:0]            TICKS_PER_UNIT   = 7'd100;
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET     = 10'd10;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET     = 8'd50;
   localparam logic [DELAY_W-1:0]    LIMIT_RESET      = 16'd1000;
   localparam logic [INTEG_W-1:0]    INTEG_MAX        = 7'd127;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic                  key0_level;
      logic                  key1_level;
      logic [DELAY_W-1:0]    delay_length;
   } item_type;

   typedef struct packed {
      logic [1:0]         key_code;
      logic               packet_pulse;
      logic               delay_busy;
      logic [DELAY_W-1:0] rx_timeout_ticks;
   } result_type;

   typedef struct packed {
      logic [DELAY_W-1:0]  packet_limit;
      logic [WINDOW_W-1:0] window_ticks;
   } cfg_type;

endpackage

// File: hw/rtl/tkdt_csr.sv
// configuration registers with the packet limit precomputed at write time
module tkdt_csr
   import tkdt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   logic [DELAY_W-1:0]  limit_ff;
   logic [DELAY_W-1:0]  limit_in;
   logic [WINDOW_W-1:0] window_ff;
   logic [16:0]         product;

   // period in hundreds of ticks, clamped to 16 bits
   always_comb begin
      product = 17'(wr_data[PERIOD_W-1:0] * TICKS_PER_UNIT);
      if (product[16]) begin
         limit_in = '1;
      end else begin
         limit_in = product[DELAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         window_ff <= WINDOW_RESET;
      end else if (wr_en) begin
         case (wr_index)
            CSR_PACKET_PERIOD: begin
               limit_ff <= limit_in;
            end
            CSR_WINDOW_TICKS: begin
               window_ff <= wr_data[WINDOW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.packet_limit = limit_ff;
   assign cfg.window_ticks = window_ff;

endmodule

// File: hw/rtl/tkdt_state.sv
// timer, counter and key integrator state with its per-beat update
module tkdt_state
   import tkdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [DELAY_W-1:0]  delay_ff,   delay_in;
   logic [DELAY_W-1:0]  rxto_ff,    rxto_in;
   logic [DELAY_W-1:0]  packet_ff,  packet_in;
   logic [INTEG_W-1:0]  integ0_ff,  integ0_in;
   logic [INTEG_W-1:0]  integ1_ff,  integ1_in;
   logic [WINDOW_W-1:0] window_ff,  window_in;
   logic [1:0]          keys_ff,    keys_in;
   logic                pulse;
   logic [DELAY_W:0]    packet_next;
   logic [WINDOW_W-1:0] window_next;
   logic [WINDOW_W-1:0] half;

   function automatic logic [INTEG_W-1:0] integrate(input logic [INTEG_W-1:0] acc,
                                                    input logic level);
      logic [INTEG_W-1:0] res;
      if (!level) begin
         res = (acc == INTEG_MAX) ? INTEG_MAX : acc + 1'b1;
      end else begin
         res = (acc == '0) ? '0 : acc - 1'b1;
      end
      return res;
   endfunction

   always_comb begin
      delay_in    = delay_ff;
      rxto_in     = rxto_ff;
      packet_in   = packet_ff;
      integ0_in   = integ0_ff;
      integ1_in   = integ1_ff;
      window_in   = window_ff;
      keys_in     = keys_ff;
      pulse       = 1'b0;
      packet_next = {1'b0, packet_ff} + 1'b1;
      window_next = window_ff + 1'b1;
      half        = cfg.window_ticks >> 1;
      case (item.req_type)
         REQ_TICK: begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - 1'b1;
            end
            rxto_in   = rxto_ff + 1'b1;
            integ0_in = integrate(integ0_ff, item.key0_level);
            integ1_in = integrate(integ1_ff, item.key1_level);
            window_in = window_next;
            // end of sampling window: judge both keys against half the window
            if (window_next == cfg.window_ticks) begin
               window_in  = '0;
               keys_in[0] = {1'b0, integ0_in} >= half;
               keys_in[1] = {1'b0, integ1_in} >= half;
            end
            if (packet_next >= {1'b0, cfg.packet_limit}) begin
               packet_in = '0;
               pulse     = 1'b1;
            end else begin
               packet_in = packet_next[DELAY_W-1:0];
            end
         end
         REQ_LOAD: begin
            delay_in = item.delay_length + 1'b1;
         end
         REQ_CLEAR: begin
            rxto_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= '0;
         rxto_ff   <= '0;
         packet_ff <= '0;
         integ0_ff <= '0;
         integ1_ff <= '0;
         window_ff <= '0;
         keys_ff   <= '0;
      end else if (step) begin
         delay_ff  <= delay_in;
         rxto_ff   <= rxto_in;
         packet_ff <= packet_in;
         integ0_ff <= integ0_in;
         integ1_ff <= integ1_in;
         window_ff <= window_in;
         keys_ff   <= keys_in;
      end
   end

   assign result.key_code         = keys_in;
   assign result.packet_pulse     = pulse;
   assign result.delay_busy       = delay_in != '0;
   assign result.rx_timeout_ticks = rxto_in;

endmodule

// File: hw/rtl/tick_key_debounce_timer.sv
// Millisecond tick block: delay counter, receive timeout counter, packet
// period pulse and two integrating key debouncers.
// Request channel (req_*): one beat per request; req_type selects a tick,
// a delay counter load (delay_length+1) or a clear of the timeout counter.
// Response channel (rsp_*): exactly one beat per request, in order, carrying
// the state after that request.
// Config channel (csr_*): always ready; index 0 packet period in hundreds
// of ticks, index 1 sampling window in ticks. Write only while idle.
// A request is held in the input register, goes through one update pass and
// is captured in the result register. Throughput: one request per cycle while
// rsp_stall is low, set by the single input register and result register.
// Reset clears all counters and integrators and restores period 10 and
// window 50. While rsp_stall is high the response holds; one more request
// is buffered in the input register, after which req_stall is raised.
module tick_key_debounce_timer
   import tkdt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic                   req_key0_level,
   input  logic                   req_key1_level,
   input  logic [DELAY_W-1:0]     req_delay_length,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_key_code,
   output logic                   rsp_packet_pulse,
   output logic                   rsp_delay_busy,
   output logic [DELAY_W-1:0]     rsp_rx_timeout_ticks,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   cfg_type    cfg;
   logic       advance;
   logic       accept;

   assign csr_ready = 1'b1;

   tkdt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // input beat moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   tkdt_state u_state (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.req_type     <= req_type;
         in_item_ff.key0_level   <= req_key0_level;
         in_item_ff.key1_level   <= req_key1_level;
         in_item_ff.delay_length <= req_delay_length;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_key_code         = rsp_ff.key_code;
   assign rsp_packet_pulse     = rsp_ff.packet_pulse;
   assign rsp_delay_busy       = rsp_ff.delay_busy;
   assign rsp_rx_timeout_ticks = rsp_ff.rx_timeout_ticks;

`ifndef SYNTHESIS
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat did not reach the result register");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_no_pulse_off_tick: assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.req_type != REQ_TICK) |=> !rsp_ff.packet_pulse)
      else $error("packet pulse on a non-tick request");
`endif

endmodule

// File: tb/sv/tick_key_debounce_checker.sv
// response checker for the tick key debounce timer: tracks state and compares each beat
module tick_key_debounce_checker
   import tkdt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [REQ_TYPE_W-1:0]  req_type,
   input  logic                   req_key0_level,
   input  logic                   req_key1_level,
   input  logic [DELAY_W-1:0]     req_delay_length,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_key_code,
   input  logic                   rsp_packet_pulse,
   input  logic                   rsp_delay_busy,
   input  logic [DELAY_W-1:0]     rsp_rx_timeout_ticks,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [PERIOD_W-1:0] period_hundreds;
   logic [WINDOW_W-1:0] window_len;
   logic [DELAY_W-1:0]  delay_left;
   logic [DELAY_W-1:0]  rx_idle;
   logic [DELAY_W-1:0]  packet_ticks;
   logic [INTEG_W-1:0]  integ0;
   logic [INTEG_W-1:0]  integ1;
   logic [WINDOW_W-1:0] window_pos;
   logic [1:0]          keys_latched;

   result_type owed_results[$];
   int errs = 0;
   int owed = 0;

   assign mismatch_count = errs;
   assign results_owed   = owed;

   // level low means the key is down: count up, otherwise count down
   function automatic logic [INTEG_W-1:0] integrate_key(logic [INTEG_W-1:0] acc, logic level);
      if (!level) begin
         return (acc == INTEG_MAX) ? acc : acc + 1'b1;
      end
      return (acc == '0) ? acc : acc - 1'b1;
   endfunction

   task automatic apply_request(input item_type req, output result_type res);
      int unsigned limit;
      int unsigned next_count;
      res = '0;
      case (req.req_type)
         REQ_TICK: begin
            if (delay_left != '0) delay_left = delay_left - 1'b1;
            rx_idle = rx_idle + 1'b1;
            integ0 = integrate_key(integ0, req.key0_level);
            integ1 = integrate_key(integ1, req.key1_level);
            window_pos = window_pos + 1'b1;
            // a window below the current count is only met again after the 8-bit wrap
            if (window_pos == window_len) begin
               keys_latched = {integ1 >= (window_len >> 1), integ0 >= (window_len >> 1)};
               window_pos = '0;
            end
            limit = period_hundreds * TICKS_PER_UNIT;
            if (limit > 32'hFFFF) limit = 32'hFFFF;
            next_count = packet_ticks + 1;
            if (next_count >= limit) begin
               packet_ticks = '0;
               res.packet_pulse = 1'b1;
            end else begin
               packet_ticks = DELAY_W'(next_count);
            end
         end
         REQ_LOAD: delay_left = req.delay_length + 1'b1;
         REQ_CLEAR: rx_idle = '0;
         default: ;
      endcase
      res.key_code         = keys_latched;
      res.delay_busy       = (delay_left != '0);
      res.rx_timeout_ticks = rx_idle;
   endtask

   function void check_field(string name, int unsigned want_v, int unsigned got_v, bit got_x);
      if (got_x || want_v != got_v) begin
         errs++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      end
   endfunction

   // everything settles by the falling edge, so sample there for the next rising edge
   always @(negedge clock) begin : watch
      item_type   req_beat;
      result_type want;
      result_type got;
      if (reset) begin
         period_hundreds = PERIOD_RESET;
         window_len      = WINDOW_RESET;
         delay_left      = '0;
         rx_idle         = '0;
         packet_ticks    = '0;
         integ0          = '0;
         integ1          = '0;
         window_pos      = '0;
         keys_latched    = '0;
         owed_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PACKET_PERIOD: period_hundreds = csr_wdata[PERIOD_W-1:0];
               CSR_WINDOW_TICKS:  window_len = csr_wdata[WINDOW_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            req_beat.req_type     = req_type;
            req_beat.key0_level   = req_key0_level;
            req_beat.key1_level   = req_key1_level;
            req_beat.delay_length = req_delay_length;
            apply_request(req_beat, want);
            owed_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.key_code         = rsp_key_code;
            got.packet_pulse     = rsp_packet_pulse;
            got.delay_busy       = rsp_delay_busy;
            got.rx_timeout_ticks = rsp_rx_timeout_ticks;
            if (owed_results.size() == 0) begin
               errs++;
               $display("%0t: response beat with none expected, actual key_code %0d timeout %0d",
                        $time, got.key_code, got.rx_timeout_ticks);
            end else begin
               want = owed_results.pop_front();
               check_field("key_code", 32'(want.key_code), 32'(got.key_code),
                           $isunknown(got.key_code));
               check_field("packet_pulse", 32'(want.packet_pulse), 32'(got.packet_pulse),
                           $isunknown(got.packet_pulse));
               check_field("delay_busy", 32'(want.delay_busy), 32'(got.delay_busy),
                           $isunknown(got.delay_busy));
               check_field("rx_timeout_ticks", 32'(want.rx_timeout_ticks),
                           32'(got.rx_timeout_ticks), $isunknown(got.rx_timeout_ticks));
            end
         end
      end
      owed = owed_results.size();
   end

endmodule

// File: tb/sv/tb_tick_key_debounce_timer.sv
// testbench top for the tick key debounce timer: clock, reset, stimulus and verdict
module tb_tick_key_debounce_timer;
   timeunit 1ns;
   timeprecision 1ps;
   import tkdt_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [REQ_TYPE_W-1:0]  req_type = REQ_TICK;
   logic                   req_key0_level = 1'b1;
   logic                   req_key1_level = 1'b1;
   logic [DELAY_W-1:0]     req_delay_length = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_key_code;
   logic                   rsp_packet_pulse;
   logic                   rsp_delay_busy;
   logic [DELAY_W-1:0]     rsp_rx_timeout_ticks;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PACKET_PERIOD;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatches;
   int owed;
   int cycle_count = 0;
   int gap_max = 0;
   int stall_max = 0;
   logic key0_now = 1'b1;
   logic key1_now = 1'b1;

   always #5ns clock = ~clock;

   tick_key_debounce_timer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_key0_level       (req_key0_level),
      .req_key1_level       (req_key1_level),
      .req_delay_length     (req_delay_length),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_key_code         (rsp_key_code),
      .rsp_packet_pulse     (rsp_packet_pulse),
      .rsp_delay_busy       (rsp_delay_busy),
      .rsp_rx_timeout_ticks (rsp_rx_timeout_ticks),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   tick_key_debounce_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_key0_level       (req_key0_level),
      .req_key1_level       (req_key1_level),
      .req_delay_length     (req_delay_length),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_key_code         (rsp_key_code),
      .rsp_packet_pulse     (rsp_packet_pulse),
      .rsp_delay_busy       (rsp_delay_busy),
      .rsp_rx_timeout_ticks (rsp_rx_timeout_ticks),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatches),
      .results_owed         (owed)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response side: after each beat hold stall for a random number of cycles
   initial begin : receiver
      int  stall_left;
      bit  took;
      stall_left = 0;
      forever begin
         @(negedge clock);
         took = rsp_valid && !rsp_stall;
         @(posedge clock);
         if (took) stall_left = $urandom_range(0, stall_max);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_req(input logic [REQ_TYPE_W-1:0] kind, input logic k0, input logic k1,
                           input logic [DELAY_W-1:0] len);
      int gap;
      bit taken;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_key0_level   <= k0;
      req_key1_level   <= k1;
      req_delay_length <= len;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // called only after a beat went in, so it always waits for that beat's response before returning
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (owed != 0) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] period,
                               input logic [CSR_DATA_W-1:0] window);
      bit taken;
      wait_drained();
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? CSR_PACKET_PERIOD : CSR_WINDOW_TICKS;
         csr_wdata <= (i == 0) ? period : window;
         do begin
            @(negedge clock);
            taken = csr_ready;
            @(posedge clock);
         end while (!taken);
      end
      csr_valid <= 1'b0;
   endtask

   // keys are held for runs so the integrators travel far, with short glitches on top
   task automatic run_phase(input logic [CSR_DATA_W-1:0] period,
                            input logic [CSR_DATA_W-1:0] window,
                            input int items, input int tick_pct, input int flip_div);
      int roll;
      int pick;
      logic [REQ_TYPE_W-1:0] kind;
      logic [DELAY_W-1:0]    len;
      logic                  k0;
      logic                  k1;
      program_regs(period, window);
      for (int n = 0; n < items; n++) begin
         if (n % 30 == 0) begin
            gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 19;
            stall_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
         end
         if ($urandom_range(0, flip_div) == 0) key0_now = ~key0_now;
         if ($urandom_range(0, flip_div) == 0) key1_now = ~key1_now;
         k0 = key0_now ^ ($urandom_range(0, 15) == 0);
         k1 = key1_now ^ ($urandom_range(0, 15) == 0);
         roll = $urandom_range(0, 99);
         if (roll < tick_pct) begin
            kind = REQ_TICK;
         end else begin
            case (roll % 4)
               0, 1: kind = REQ_LOAD;
               2: kind = REQ_CLEAR;
               default: kind = REQ_UNUSED;
            endcase
         end
         pick = $urandom_range(0, 9);
         if (pick < 6) len = DELAY_W'($urandom_range(0, 30));
         else if (pick < 9) len = DELAY_W'($urandom());
         else len = $urandom_range(0, 1) ? 16'hFFFF : 16'hFFFE;
         send_req(kind, k0, k1, len);
         if ($urandom_range(0, 59) == 0) wait_drained();
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part under the reset settings
      send_req(REQ_LOAD, 1'b1, 1'b1, 16'd0);
      send_req(REQ_TICK, 1'b1, 1'b1, 16'd0);
      send_req(REQ_LOAD, 1'b0, 1'b0, 16'hFFFF);   // wraps to zero, stays idle
      send_req(REQ_LOAD, 1'b1, 1'b1, 16'hFFFE);
      send_req(REQ_LOAD, 1'b1, 1'b0, 16'h5555);
      send_req(REQ_LOAD, 1'b0, 1'b1, 16'hAAAA);
      send_req(REQ_CLEAR, 1'b1, 1'b1, 16'h0000);
      send_req(REQ_TICK, 1'b0, 1'b0, 16'hFFFF);
      send_req(REQ_TICK, 1'b0, 1'b1, 16'h0000);
      send_req(REQ_TICK, 1'b1, 1'b0, 16'h0000);
      send_req(REQ_UNUSED, 1'b0, 1'b0, 16'hFFFF);
      send_req(REQ_UNUSED, 1'b1, 1'b1, 16'h0000);
      send_req(REQ_LOAD, 1'b1, 1'b1, 16'd2);
      for (int i = 0; i < 4; i++) send_req(REQ_TICK, 1'b0, 1'b0, 16'h0000);
      send_req(REQ_CLEAR, 1'b0, 1'b0, 16'hFFFF);
      send_req(REQ_TICK, 1'b1, 1'b1, 16'h0000);

      // period 0 pulses every tick, window of one reads both keys pressed
      run_phase(10'd0, 10'd1, 50, 75, 3);
      run_phase(10'd1, 10'd2, 60, 75, 8);
      // upper data bits are dropped for the window register
      run_phase(10'd655, 10'h3FF, 60, 75, 40);
      // window below the running count
      run_phase(10'd1, 10'd5, 40, 75, 6);
      // clamped period and a window of zero, long enough to wrap the window count
      run_phase(10'd1023, 10'd0, 220, 95, 150);
      run_phase(10'd2, 10'd9, 60, 80, 20);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
